// ===== hw/rtl/crc8_packet_framer_deframer_assert.svh =====
// Assertion macros for the CRC-8 packet framer/deframer.
// Used by the top-level module only; no other dependencies.
`ifndef CRC8_PACKET_FRAMER_DEFRAMER_ASSERT_SVH
`define CRC8_PACKET_FRAMER_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CPFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpfd assertion failed");

// next-cycle implication
`define CPFD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpfd assertion failed");

`else

`define CPFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define CPFD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/crc8pfd_pkg.sv =====
// Shared types, frame constants and the CRC-8 byte step for the framer/deframer.
// No dependencies.
`default_nettype none

package crc8pfd_pkg;

  typedef enum logic [1:0] {
    OP_TRANSMIT = 2'd0,
    OP_START_RX = 2'd1,
    OP_RX_BYTE  = 2'd2,
    OP_POLL     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_TIMEOUT   = 2'd0,
    ST_CRC_OK    = 2'd1,
    ST_CRC_ERROR = 2'd2
  } status_t;

  typedef enum logic {
    KIND_TX_BYTE = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_t;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  CRC_POLY      = 8'h8C;

  // frame layout: 4 sync bytes, 4 payload bytes, crc, trailer
  localparam logic [7:0] SYNC_A  = 8'hAA;
  localparam logic [7:0] SYNC_B  = 8'h2D;
  localparam logic [7:0] SYNC_C  = 8'hD4;
  localparam logic [7:0] TRAILER = 8'h00;

  localparam logic [3:0] BEAT_PAYLOAD = 4'd4;
  localparam logic [3:0] BEAT_CRC     = 4'd8;
  localparam logic [3:0] BEAT_LAST    = 4'd9;

  // rx_count: 0 = drop next byte, n = n-1 bytes stored; RX_CRC_SLOT = crc byte next
  localparam logic [2:0] RX_CRC_SLOT = 3'd5;

  // Dallas/Maxim CRC-8, reflected, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc8_packet_framer_deframer.sv =====
// CRC-8 (Dallas/Maxim) radio packet framer and deframer, top level.
// Depends on crc8pfd_pkg and crc8_packet_framer_deframer_assert.svh.
// The first result beat of an item passes the job register and then the output register.
// Throughput: one item per cycle while the output is not stalled; a transmit emits ten beats,
// one per cycle unless stalled, and any next item waits until the last beat enters the output register.
// Reset (rst, synchronous, active high): receiver idle, job and output registers empty, timeout = 1000.
`default_nettype none

module crc8_packet_framer_deframer
  import crc8pfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // configuration: receive_timeout
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,

  // input beats
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  payload_0,
  input  wire logic [7:0]  payload_1,
  input  wire logic [7:0]  payload_2,
  input  wire logic [7:0]  payload_3,
  input  wire logic [7:0]  rx_byte,

  // result beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       tx_byte,
  output logic             last_item,
  output logic [1:0]       rx_status,
  output logic [7:0]       rx_payload_0,
  output logic [7:0]       rx_payload_1,
  output logic [7:0]       rx_payload_2,
  output logic [7:0]       rx_payload_3,
  output logic [7:0]       rx_crc
);

  `include "crc8_packet_framer_deframer_assert.svh"

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [15:0] receive_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      receive_timeout <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver state
  // ---------------------------------------------------------------------------
  logic        rx_active, rx_active_next;
  logic [2:0]  rx_count, rx_count_next;
  logic [15:0] polls_left, polls_left_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  rx_buffer [4];   // payload bytes; the crc byte is used as it arrives

  // ---------------------------------------------------------------------------
  // Job register: the result set of the last accepted item, drained beat by beat.
  // A transmit job walks job_idx 0..9; a report is a single beat.
  // ---------------------------------------------------------------------------
  logic        job_valid;
  logic [3:0]  job_idx;
  kind_t       job_kind;
  logic [7:0]  job_b [4];
  logic [7:0]  job_crc;   // tx: crc built while payload beats go out; report: crc as received
  status_t     job_status;
  logic        job_last;

  // output register
  kind_t       out_kind;
  status_t     out_status;

  logic in_fire;
  logic out_free;
  logic out_load;

  assign job_last = (job_kind == KIND_REPORT) || (job_idx == BEAT_LAST);
  assign out_free = !out_valid || out_ready;
  assign out_load = job_valid && out_free;
  // a new job may land while the current one hands over its final beat
  assign in_ready = !job_valid || (job_last && out_free);
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Per-item decode: receiver update and job creation
  // ---------------------------------------------------------------------------
  logic        tx_load;
  logic        rep_load;
  logic        rep_with_data;
  status_t     rep_status;
  logic        buf_we;
  logic [1:0]  buf_slot;
  logic [15:0] polls_dec;

  assign polls_dec = polls_left - 16'd1;
  // rx_count 1..4 maps to slots 0..3
  assign buf_slot  = rx_count[1:0] - 2'd1;

  always_comb begin
    rx_active_next   = rx_active;
    rx_count_next    = rx_count;
    polls_left_next  = polls_left;
    running_crc_next = running_crc;
    tx_load          = 1'b0;
    rep_load         = 1'b0;
    rep_with_data    = 1'b0;
    rep_status       = ST_TIMEOUT;
    buf_we           = 1'b0;
    if (in_fire) begin
      case (op_t'(op))
        OP_TRANSMIT: begin
          // receive state is left alone
          tx_load = 1'b1;
        end
        OP_START_RX: begin
          rx_count_next    = 3'd0;
          running_crc_next = 8'h00;
          polls_left_next  = receive_timeout;
          if (receive_timeout == 16'd0) begin
            rx_active_next = 1'b0;
            rep_load       = 1'b1;
          end else begin
            rx_active_next = 1'b1;
          end
        end
        OP_RX_BYTE: begin
          if (rx_active) begin
            if (rx_count == 3'd0) begin
              // leading byte is dropped
              rx_count_next = 3'd1;
            end else if (rx_count > RX_CRC_SLOT) begin
              rx_active_next = 1'b0;
            end else if (rx_count < RX_CRC_SLOT) begin
              buf_we           = 1'b1;
              running_crc_next = crc8_byte(running_crc, rx_byte);
              rx_count_next    = rx_count + 3'd1;
            end else begin
              // crc byte: close the receive and report
              rx_count_next  = rx_count + 3'd1;
              rx_active_next = 1'b0;
              rep_load       = 1'b1;
              rep_with_data  = 1'b1;
              rep_status     = (running_crc == rx_byte) ? ST_CRC_OK : ST_CRC_ERROR;
            end
          end
        end
        OP_POLL: begin
          if (rx_active) begin
            polls_left_next = polls_dec;
            if (polls_dec == 16'd0) begin
              rx_active_next = 1'b0;
              rep_load       = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_active   <= 1'b0;
      rx_count    <= 3'd0;
      polls_left  <= 16'd0;
      running_crc <= 8'h00;
    end else begin
      rx_active   <= rx_active_next;
      rx_count    <= rx_count_next;
      polls_left  <= polls_left_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      rx_buffer[buf_slot] <= rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Job register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= 4'd0;
    end else if (tx_load || rep_load) begin
      job_valid <= 1'b1;
      job_idx   <= 4'd0;
    end else if (out_load) begin
      if (job_last) begin
        job_valid <= 1'b0;
      end else begin
        job_idx <= job_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tx_load) begin
      job_kind   <= KIND_TX_BYTE;
      job_b[0]   <= payload_0;
      job_b[1]   <= payload_1;
      job_b[2]   <= payload_2;
      job_b[3]   <= payload_3;
      job_crc    <= 8'h00;
      job_status <= ST_TIMEOUT;
    end else if (rep_load) begin
      job_kind   <= KIND_REPORT;
      job_status <= rep_status;
      if (rep_with_data) begin
        // last payload byte was stored at accept time of the previous beat
        job_b[0] <= rx_buffer[0];
        job_b[1] <= rx_buffer[1];
        job_b[2] <= rx_buffer[2];
        job_b[3] <= rx_buffer[3];
        job_crc  <= rx_byte;
      end else begin
        job_b[0] <= 8'h00;
        job_b[1] <= 8'h00;
        job_b[2] <= 8'h00;
        job_b[3] <= 8'h00;
        job_crc  <= 8'h00;
      end
    end else if (out_load && job_kind == KIND_TX_BYTE && job_idx[3:2] == 2'b01) begin
      // fold each payload byte into the frame crc as it goes out; done by beat 8
      job_crc <= crc8_byte(job_crc, job_b[job_idx[1:0]]);
    end
  end

  // ---------------------------------------------------------------------------
  // Beat select
  // ---------------------------------------------------------------------------
  logic [7:0] beat_tx_byte;

  always_comb begin
    if (job_idx < BEAT_PAYLOAD) begin
      case (job_idx[1:0])
        2'd2:    beat_tx_byte = SYNC_B;
        2'd3:    beat_tx_byte = SYNC_C;
        default: beat_tx_byte = SYNC_A;
      endcase
    end else if (job_idx < BEAT_CRC) begin
      beat_tx_byte = job_b[job_idx[1:0]];
    end else if (job_idx == BEAT_CRC) begin
      beat_tx_byte = job_crc;
    end else begin
      beat_tx_byte = TRAILER;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= job_kind;
      if (job_kind == KIND_TX_BYTE) begin
        tx_byte      <= beat_tx_byte;
        last_item    <= (job_idx == BEAT_LAST);
        out_status   <= ST_TIMEOUT;
        rx_payload_0 <= 8'h00;
        rx_payload_1 <= 8'h00;
        rx_payload_2 <= 8'h00;
        rx_payload_3 <= 8'h00;
        rx_crc       <= 8'h00;
      end else begin
        tx_byte      <= 8'h00;
        last_item    <= 1'b1;
        out_status   <= job_status;
        rx_payload_0 <= job_b[0];
        rx_payload_1 <= job_b[1];
        rx_payload_2 <= job_b[2];
        rx_payload_3 <= job_b[3];
        rx_crc       <= job_crc;
      end
    end
  end

  assign kind      = out_kind;
  assign rx_status = out_status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CPFD_ASSERT_IMP(a_active_has_budget, clk, rst, rx_active, polls_left != 16'd0)
  `CPFD_ASSERT_IMP(a_active_count_range, clk, rst, rx_active, rx_count <= RX_CRC_SLOT)
  `CPFD_ASSERT_IMP(a_tx_idx_range, clk, rst, job_valid && job_kind == KIND_TX_BYTE, job_idx <= BEAT_LAST)
  `CPFD_ASSERT_NXT(a_tx_job_start, clk, rst, in_fire && op == OP_TRANSMIT, job_valid && job_idx == 4'd0 && job_kind == KIND_TX_BYTE)

endmodule

`default_nettype wire

// ===== tb/sv/crc8pfd_check_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the CRC-8 packet framer/deframer: next-result predictor and beat checker.
// Depends on crc8pfd_pkg for the op, status and kind codes.

package crc8pfd_check_pkg;

  import crc8pfd_pkg::*;

  class frame_scoreboard;

    localparam logic [7:0]  REFLECTED_POLY = 8'h8C;
    localparam logic [7:0]  PREAMBLE       = 8'hAA;
    localparam logic [7:0]  SYNC_HI        = 8'h2D;
    localparam logic [7:0]  SYNC_LO        = 8'hD4;
    localparam logic [7:0]  TRAILER_BYTE   = 8'h00;
    localparam logic [15:0] BUDGET_AT_RST  = 16'd1000;
    localparam logic [2:0]  LAST_SLOT      = 3'd5;   // fill level at which the crc byte lands
    localparam int          MAX_PRINTED    = 200;

    typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       last;
      logic [1:0] status;
      logic [7:0] pay0;
      logic [7:0] pay1;
      logic [7:0] pay2;
      logic [7:0] pay3;
      logic [7:0] crc;
    } beat_t;

    beat_t       expected_beats[$];
    logic [15:0] budget_cfg;
    logic        armed;
    logic [2:0]  rx_fill;
    logic [15:0] polls_remaining;
    logic [7:0]  crc_acc;
    logic [7:0]  rx_store [5];
    int          errors;
    int          beats_seen;

    function new();
      budget_cfg      = BUDGET_AT_RST;
      armed           = 1'b0;
      rx_fill         = '0;
      polls_remaining = '0;
      crc_acc         = '0;
      rx_store        = '{default: 8'h00};
      errors          = 0;
      beats_seen      = 0;
    endfunction

    // bit-serial 1-Wire style update, lsb first
    static function logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = acc;
      d = data;
      repeat (8) begin
        mix = c[0] ^ d[0];
        c   = c >> 1;
        d   = d >> 1;
        if (mix) c = c ^ REFLECTED_POLY;
      end
      return c;
    endfunction

    static function logic [7:0] frame_crc(logic [7:0] b0, b1, b2, b3);
      return crc8_step(crc8_step(crc8_step(crc8_step(8'h00, b0), b1), b2), b3);
    endfunction

    function void set_timeout(logic [15:0] v);
      budget_cfg = v;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void push_tx(logic [7:0] b, logic is_last);
      beat_t bt;
      bt         = '0;
      bt.kind    = KIND_TX_BYTE;
      bt.tx_byte = b;
      bt.last    = is_last;
      expected_beats.push_back(bt);
    endfunction

    function void push_report(status_t s);
      beat_t bt;
      bt        = '0;
      bt.kind   = KIND_REPORT;
      bt.last   = 1'b1;
      bt.status = s;
      if (s != ST_TIMEOUT) begin
        bt.pay0 = rx_store[0];
        bt.pay1 = rx_store[1];
        bt.pay2 = rx_store[2];
        bt.pay3 = rx_store[3];
        bt.crc  = rx_store[4];
      end
      expected_beats.push_back(bt);
    endfunction

    // Predicts the beats caused by one accepted input; returns 1 when the block ignores it.
    function bit note_input(op_t code, logic [7:0] b0, b1, b2, b3, rb);
      logic [7:0] frame [10];
      case (code)
        OP_TRANSMIT: begin
          frame = '{PREAMBLE, PREAMBLE, SYNC_HI, SYNC_LO, b0, b1, b2, b3,
                    frame_crc(b0, b1, b2, b3), TRAILER_BYTE};
          foreach (frame[i]) push_tx(frame[i], i == 9);
          return 1'b0;
        end
        OP_START_RX: begin
          rx_fill         = '0;
          crc_acc         = '0;
          polls_remaining = budget_cfg;
          armed           = (budget_cfg != 0);
          if (!armed) push_report(ST_TIMEOUT);
          return 1'b0;
        end
        default: ;
      endcase
      if (!armed) return 1'b1;
      if (code == OP_RX_BYTE) begin
        if (rx_fill == 0) begin
          rx_fill = 3'd1;                       // preamble tail, dropped
        end else if (rx_fill > LAST_SLOT) begin
          armed = 1'b0;
        end else begin
          rx_store[rx_fill - 3'd1] = rb;
          rx_fill = rx_fill + 3'd1;
          if (rx_fill <= LAST_SLOT) begin
            crc_acc = crc8_step(crc_acc, rb);
          end else begin
            armed = 1'b0;
            push_report((crc_acc == rb) ? ST_CRC_OK : ST_CRC_ERROR);
          end
        end
      end else begin
        polls_remaining = polls_remaining - 16'd1;
        if (polls_remaining == 0) begin
          armed = 1'b0;
          push_report(ST_TIMEOUT);
        end
      end
      return 1'b0;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH %s", msg);
      errors++;
    endtask

    task cmp(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %02h want %02h", beats_seen, name, got, want));
    endtask

    task check_result(logic k, logic [7:0] txb, logic lst, logic [1:0] st,
                      logic [7:0] p0, p1, p2, p3, fcs);
      beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat %0d with nothing expected: kind %0d byte %02h status %0d",
                         beats_seen, k, txb, st));
      end else begin
        want = expected_beats.pop_front();
        cmp("kind", 8'(k), 8'(want.kind));
        cmp("tx_byte", txb, want.tx_byte);
        cmp("last_item", 8'(lst), 8'(want.last));
        cmp("rx_status", 8'(st), 8'(want.status));
        cmp("rx_payload_0", p0, want.pay0);
        cmp("rx_payload_1", p1, want.pay1);
        cmp("rx_payload_2", p2, want.pay2);
        cmp("rx_payload_3", p3, want.pay3);
        cmp("rx_crc", fcs, want.crc);
      end
      beats_seen++;
    endtask

  endclass

endpackage

// ===== tb/sv/tb_crc8_packet_framer_deframer.sv =====
`timescale 1ns / 1ps
// Top-level testbench for crc8_packet_framer_deframer: directed and random traffic, checked
// beat by beat against a predictor. Depends on crc8pfd_pkg and crc8pfd_check_pkg.

module tb_crc8_packet_framer_deframer;

  import crc8pfd_pkg::*;
  import crc8pfd_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat moving on either side
  localparam int SETTLE_CYCLES  = 8;     // first result beat goes through the job and output registers after accept
  localparam int PHASE_ITEMS    = 85;    // counted items per random phase

  // block ports; the driven inputs are known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [7:0]  payload_0 = '0;
  logic [7:0]  payload_1 = '0;
  logic [7:0]  payload_2 = '0;
  logic [7:0]  payload_3 = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last_item;
  logic [1:0]  rx_status;
  logic [7:0]  rx_payload_0;
  logic [7:0]  rx_payload_1;
  logic [7:0]  rx_payload_2;
  logic [7:0]  rx_payload_3;
  logic [7:0]  rx_crc;

  frame_scoreboard sb;
  int gap_pct    = 0;   // chance per beat slot that the sender holds off
  int stall_pct  = 0;   // chance per cycle that the receiver deasserts ready
  int fed_items  = 0;   // accepted items the block does not simply drop
  int idle_count = 0;

  crc8_packet_framer_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .payload_0    (payload_0),
    .payload_1    (payload_1),
    .payload_2    (payload_2),
    .payload_3    (payload_3),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .tx_byte      (tx_byte),
    .last_item    (last_item),
    .rx_status    (rx_status),
    .rx_payload_0 (rx_payload_0),
    .rx_payload_1 (rx_payload_1),
    .rx_payload_2 (rx_payload_2),
    .rx_payload_3 (rx_payload_3),
    .rx_crc       (rx_crc)
  );

  always #1 clk = ~clk;

  // receiver side: random backpressure per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // every result beat that moves is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      sb.check_result(kind, tx_byte, last_item, rx_status, rx_payload_0, rx_payload_1,
                      rx_payload_2, rx_payload_3, rx_crc);
    end
  end

  // hang detector: restarts whenever a beat moves on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // any byte value
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Presents one item, holds it until taken, then hands it to the predictor.
  // Here valid is only dropped for a sender gap, never between back-to-back items.
  task automatic send_item(input op_t code, input logic [7:0] b0, b1, b2, b3, rb);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= code;
    payload_0 <= b0;
    payload_1 <= b1;
    payload_2 <= b2;
    payload_3 <= b3;
    rx_byte   <= rb;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (!sb.note_input(code, b0, b1, b2, b3, rb)) fed_items++;
  endtask

  // non-transmit item; the payload fields are don't-care and get random junk
  task automatic ctl(input op_t code, input logic [7:0] rb);
    send_item(code, rand_byte(), rand_byte(), rand_byte(), rand_byte(), rb);
  endtask

  task automatic xmit(input logic [7:0] b0, b1, b2, b3);
    send_item(OP_TRANSMIT, b0, b1, b2, b3, rand_byte());
  endtask

  // payload byte biased toward all-zeros and all-ones
  function automatic logic [7:0] pay_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return rand_byte();
    endcase
  endfunction

  // Well-formed receive: start, a dropped lead byte, four payload bytes and the crc.
  // A bad crc is flipped by a nonzero mask so it always mismatches. Poll ticks and
  // the odd transmit get mixed in when tick_pct is nonzero.
  task automatic rx_sequence(input logic [7:0] b0, b1, b2, b3, input bit good,
                             input int tick_pct);
    logic [7:0] body [4];
    logic [7:0] fcs;
    body = '{b0, b1, b2, b3};
    fcs  = frame_scoreboard::frame_crc(b0, b1, b2, b3);
    if (!good) fcs = fcs ^ 8'($urandom_range(1, 255));
    ctl(OP_START_RX, rand_byte());
    ctl(OP_RX_BYTE, rand_byte());
    for (int i = 0; i < 5; i++) begin
      if ($urandom_range(0, 99) < tick_pct) ctl(OP_POLL, rand_byte());
      if (tick_pct != 0 && $urandom_range(0, 19) == 0)
        xmit(pay_byte(), pay_byte(), pay_byte(), pay_byte());
      ctl(OP_RX_BYTE, (i < 4) ? body[i] : fcs);
    end
  endtask

  // Drain: all expected beats out, then a settling wait for items still in flight
  // that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic write_timeout(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_timeout(v);
  endtask

  // Mostly complete receives with random content; the rest transmits, noise items
  // of any op, and receives cut short and left to time out.
  task automatic random_phase(input int gap, input int stall, input logic [15:0] budget);
    int target;
    int pick;
    settle();
    write_timeout(budget);
    gap_pct   = gap;
    stall_pct = stall;
    target    = fed_items + PHASE_ITEMS;
    while (fed_items < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        rx_sequence(pay_byte(), pay_byte(), pay_byte(), pay_byte(),
                    $urandom_range(0, 3) != 0, 15);
      end else if (pick < 8) begin
        xmit(pay_byte(), pay_byte(), pay_byte(), pay_byte());
      end else if (pick == 8) begin
        send_item(op_t'($urandom_range(0, 3)), rand_byte(), rand_byte(), rand_byte(),
                  rand_byte(), rand_byte());
      end else begin
        ctl(OP_START_RX, rand_byte());
        repeat ($urandom_range(0, 4)) ctl(OP_RX_BYTE, rand_byte());
        repeat ($urandom_range(1, 10)) ctl(OP_POLL, rand_byte());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset budget of 1000 ---
    xmit(8'h00, 8'h00, 8'h00, 8'h00);
    xmit(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // byte and tick with the receiver idle: dropped silently
    ctl(OP_RX_BYTE, 8'h5A);
    ctl(OP_POLL, 8'h00);
    // partial receive, a frame sent while armed, then a start that restarts it
    ctl(OP_START_RX, 8'h00);
    ctl(OP_RX_BYTE, 8'h11);
    ctl(OP_RX_BYTE, 8'h22);
    xmit(8'h12, 8'h34, 8'h56, 8'h78);
    rx_sequence(8'hDE, 8'hAD, 8'hBE, 8'hEF, 1'b1, 0);
    // all-zero payload with a corrupted crc
    rx_sequence(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0);

    // zero budget: start reports timeout at once, the tick after it is dropped
    settle();
    write_timeout(16'h0000);
    ctl(OP_START_RX, 8'hFF);
    ctl(OP_POLL, 8'hFF);

    // arm with budget 3, then lower the register: the armed receive keeps 3,
    // and received bytes do not spend it
    settle();
    write_timeout(16'd3);
    ctl(OP_START_RX, 8'h00);
    settle();
    write_timeout(16'd1);
    ctl(OP_POLL, 8'h00);
    ctl(OP_RX_BYTE, 8'hFF);
    ctl(OP_POLL, 8'h00);
    ctl(OP_POLL, 8'h00);

    // --- random phases: idling pattern and budget change per phase ---
    random_phase(0, 0, 16'hFFFF);
    random_phase(50, 0, 16'($urandom_range(1, 8)));
    random_phase(0, 50, 16'd1);
    random_phase(20, 20, 16'($urandom_range(2, 6)));

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/crc8pfd_pkg.sv
hw/rtl/crc8_packet_framer_deframer.sv
tb/sv/crc8pfd_check_pkg.sv
tb/sv/tb_crc8_packet_framer_deframer.sv
